// ===== src/lpr_pkg.sv =====
package lpr_pkg;

  // Default sizing of the list
  localparam int NUM_FRAMES_DEF   = 16;
  localparam int PAGE_ID_BITS_DEF = 20;

  // Fixed width of the resident count field in a result word
  localparam int COUNT_FIELD_BITS = 5;

  // Command selector carried on the input tuser
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_EVICT  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EVWAIT,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

// ===== src/lpr_ram.sv =====
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register one read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lru_page_replacement_list.sv =====
// LRU page-replacement list with visited marks.
// Input channel in_*: one word is one command. in_tuser carries the command
// (insert, touch, evict, tick) and in_tdata the page id for insert and touch.
// Output channel out_*: exactly one result word per command, in order.
// out_tuser gives the victim flag and the status, out_tdata the victim page
// and the number of resident pages after the command.
// Commands are handled one at a time. An insert passes through ST_EXEC and
// ST_RESP; an evict reads its victim in ST_EXEC and takes it in ST_EVWAIT;
// touch and tick walk the resident pages in ST_SCAN. An evict, touch or tick
// on an empty list and a dropped insert go from ST_EXEC straight to ST_RESP.
// The next command is accepted once the sequencer returns to ST_IDLE, when
// its result is loaded into the output register. Touch and tick step through
// the list in one RAM read and at most one RAM write per cycle; the list sits
// in a ping-pong pair of RAM banks, tick rebuilding it into the other bank.
// A finished result is held in an output register, so the next command is
// accepted while it waits; a further result waits in the sequencer until the
// receiver takes the held word.
// Reset empties the list; no clearing pass is needed and the block accepts
// a command in the first cycle after reset.
module lru_page_replacement_list #(
  parameter int NUM_FRAMES   = lpr_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_ID_BITS = lpr_pkg::PAGE_ID_BITS_DEF,
  localparam int IN_W  = ((PAGE_ID_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((PAGE_ID_BITS + lpr_pkg::COUNT_FIELD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // page_id
  input  logic [1:0]       in_tuser,   // cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // victim_page, resident_count
  output logic [2:0]       out_tuser   // victim_valid, status
);

  localparam int IW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int AW = $clog2(2 * NUM_FRAMES);
  localparam int P  = PAGE_ID_BITS;

  // Map a list position to its slot in the circular bank
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [IW-1:0] pos);
    logic [IW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IW+1)'(NUM_FRAMES)) begin
      sum = sum - (IW+1)'(NUM_FRAMES);
    end
    return sum[IW-1:0];
  endfunction

  // Step a slot back by one with wrap
  function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] s);
    return (s == '0) ? IW'(NUM_FRAMES - 1) : s - 1'b1;
  endfunction

  // RAM address of a slot in a bank
  function automatic logic [AW-1:0] ram_addr(input logic bank,
                                             input logic [IW-1:0] s);
    return AW'(s) + (bank ? AW'(NUM_FRAMES) : AW'(0));
  endfunction

  lpr_pkg::state_t  state_r, state_nxt;
  lpr_pkg::cmd_t    cmd_r;
  logic [P-1:0]     page_r;
  logic [IW-1:0]    head_r, head_nxt;
  logic             bank_r, bank_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    rd_i_r, rd_i_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_addr_r, pend_addr_nxt;
  logic [IW-1:0]    front_r, front_nxt;
  logic [IW-1:0]    back_r, back_nxt;
  logic             found_r, found_nxt;

  // Result staging and output register
  logic             res_vvalid_r, res_vvalid_nxt;
  logic [P-1:0]     res_page_r, res_page_nxt;
  lpr_pkg::status_t res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_vvalid_r;
  logic [P-1:0]     out_page_r;
  lpr_pkg::status_t out_status_r;
  logic [lpr_pkg::COUNT_FIELD_BITS-1:0] out_count_r;
  logic             out_load;

  // RAM port
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [P:0]       ram_wdata, ram_rdata;
  logic             rd_mark;
  logic [P-1:0]     rd_page;
  logic [CW-1:0]    last_pos;
  logic             accept;

  assign rd_mark  = ram_rdata[P];
  assign rd_page  = ram_rdata[P-1:0];
  assign last_pos = count_r - 1'b1;
  assign accept   = in_tvalid && in_tready;

  lpr_ram #(
    .WIDTH (P + 1),
    .DEPTH (2 * NUM_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpr_pkg::ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Hold payload and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= lpr_pkg::cmd_t'(in_tuser);
      page_r <= in_tdata[P-1:0];
    end
    rd_i_r       <= rd_i_nxt;
    pend_addr_r  <= pend_addr_nxt;
    front_r      <= front_nxt;
    back_r       <= back_nxt;
    found_r      <= found_nxt;
    res_vvalid_r <= res_vvalid_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_vvalid_r <= res_vvalid_r;
      out_page_r   <= res_page_r;
      out_status_r <= res_status_r;
      out_count_r  <= lpr_pkg::COUNT_FIELD_BITS'(count_r);
    end
  end

  // Sequence each command through the RAM
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    bank_nxt       = bank_r;
    rd_i_nxt       = rd_i_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    found_nxt      = found_r;
    res_vvalid_nxt = res_vvalid_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    out_load       = 1'b0;
    in_tready      = 1'b0;

    case (state_r)
      lpr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = lpr_pkg::ST_EXEC;
        end
      end

      lpr_pkg::ST_EXEC: begin
        res_vvalid_nxt = 1'b0;
        res_page_nxt   = '0;
        res_status_nxt = lpr_pkg::STAT_OK;
        rd_i_nxt       = '0;
        front_nxt      = '0;
        back_nxt       = '0;
        found_nxt      = 1'b0;
        state_nxt      = lpr_pkg::ST_RESP;
        case (cmd_r)
          lpr_pkg::CMD_INSERT: begin
            if (count_r == CW'(NUM_FRAMES)) begin
              res_status_nxt = lpr_pkg::STAT_FULL;
            end else begin
              // Push at the most-recent end with the mark set
              head_nxt  = slot_dec(head_r);
              ram_we    = 1'b1;
              ram_waddr = ram_addr(bank_r, slot_dec(head_r));
              ram_wdata = {1'b1, page_r};
              count_nxt = count_r + 1'b1;
            end
          end
          lpr_pkg::CMD_EVICT: begin
            if (count_r == '0) begin
              res_status_nxt = lpr_pkg::STAT_EMPTY;
            end else begin
              // Fetch the least-recent entry and drop it
              ram_re    = 1'b1;
              ram_raddr = ram_addr(bank_r, slot_of(head_r, last_pos[IW-1:0]));
              count_nxt = last_pos;
              state_nxt = lpr_pkg::ST_EVWAIT;
            end
          end
          lpr_pkg::CMD_TOUCH: begin
            if (count_r == '0) begin
              res_status_nxt = lpr_pkg::STAT_ABSENT;
            end else begin
              state_nxt = lpr_pkg::ST_SCAN;
            end
          end
          lpr_pkg::CMD_TICK: begin
            if (count_r != '0) begin
              state_nxt = lpr_pkg::ST_SCAN;
            end
          end
          default: begin
            state_nxt = lpr_pkg::ST_RESP;
          end
        endcase
      end

      lpr_pkg::ST_EVWAIT: begin
        res_vvalid_nxt = 1'b1;
        res_page_nxt   = rd_page;
        state_nxt      = lpr_pkg::ST_RESP;
      end

      lpr_pkg::ST_SCAN: begin
        // Issue the next read while the previous one comes back
        if (rd_i_r != count_r) begin
          ram_re        = 1'b1;
          ram_raddr     = ram_addr(bank_r, slot_of(head_r, rd_i_r[IW-1:0]));
          pend_addr_nxt = ram_raddr;
          rd_i_nxt      = rd_i_r + 1'b1;
          pend_nxt      = 1'b1;
        end
        if (pend_r) begin
          if (cmd_r == lpr_pkg::CMD_TOUCH) begin
            // Set the mark on every matching entry in place
            if (rd_page == page_r) begin
              ram_we    = 1'b1;
              ram_waddr = pend_addr_r;
              ram_wdata = {1'b1, rd_page};
              found_nxt = 1'b1;
            end
          end else begin
            // Rebuild into the other bank: visited to the front, others to the back
            ram_we    = 1'b1;
            ram_wdata = {1'b0, rd_page};
            if (rd_mark) begin
              front_nxt = slot_dec(front_r);
              ram_waddr = ram_addr(!bank_r, slot_dec(front_r));
            end else begin
              back_nxt  = back_r + 1'b1;
              ram_waddr = ram_addr(!bank_r, back_r);
            end
          end
        end
        if (rd_i_r == count_r) begin
          state_nxt = lpr_pkg::ST_RESP;
          if (cmd_r == lpr_pkg::CMD_TOUCH) begin
            res_status_nxt = found_nxt ? lpr_pkg::STAT_OK : lpr_pkg::STAT_ABSENT;
          end else begin
            bank_nxt = !bank_r;
            head_nxt = front_nxt;
          end
        end
      end

      lpr_pkg::ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = lpr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  // Advance the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_count_r, out_page_r});
  assign out_tuser  = {out_status_r, out_vvalid_r};

endmodule

// ===== src/lpr_checker.sv =====
module lpr_checker #(
  parameter int NUM_FRAMES   = lpr_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_ID_BITS = lpr_pkg::PAGE_ID_BITS_DEF,
  localparam int OUT_W = ((PAGE_ID_BITS + lpr_pkg::COUNT_FIELD_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [2:0]       out_tuser
);

  localparam int P = PAGE_ID_BITS;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Commands are taken one at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while another is in flight");

  // A returned victim always reports success
  a_victim_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == lpr_pkg::STAT_OK)
    else $error("victim returned with a failure status");

  // Evict on an empty list gives no page and an empty count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == lpr_pkg::STAT_EMPTY |->
      !out_tuser[0] && out_tdata[P-1:0] == '0 && out_tdata[P+4:P] == '0)
    else $error("empty evict reported a page or a count");

  // The count never exceeds the frame total
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[P+4:P] <= NUM_FRAMES)
    else $error("resident count above frame total");

endmodule

bind lru_page_replacement_list lpr_checker #(
  .NUM_FRAMES   (NUM_FRAMES),
  .PAGE_ID_BITS (PAGE_ID_BITS)
) u_lpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/lru_page_replacement_list_tb.sv =====
`timescale 1ns / 100ps

module lru_page_replacement_list_tb;

  localparam int PB        = lpr_pkg::PAGE_ID_BITS_DEF;
  localparam int NF        = lpr_pkg::NUM_FRAMES_DEF;
  localparam int CB        = lpr_pkg::COUNT_FIELD_BITS;
  localparam int IN_W      = ((PB + 7) / 8) * 8;
  localparam int OUT_W     = ((PB + CB + 7) / 8) * 8;
  localparam int POOL_SIZE = 24;
  localparam int MAX_CYCLES = 200000;

  // One command word; a drain marker holds the sender until all results are in
  typedef struct {
    lpr_pkg::cmd_t cmd;
    logic [PB-1:0] page;
    bit            drain;
  } command_item_t;

  typedef struct {
    bit               victim_valid;
    logic [PB-1:0]    victim_page;
    lpr_pkg::status_t status;
    logic [CB-1:0]    resident;
  } outcome_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // page_id
  logic [1:0]       in_tuser;   // cmd
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // victim_page, resident_count
  logic [2:0]       out_tuser;  // victim_valid, status

  // Shadow copy of the resident list, most-recent end at index 0
  logic [PB-1:0] shadow_pages [NF];
  bit            shadow_marks [NF];
  int            shadow_count;

  command_item_t command_queue[$];
  outcome_t      awaited_outcomes[$];
  logic [PB-1:0] page_pool [POOL_SIZE];

  bit in_taken;
  int errors;
  int cycles;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_phase;

  lru_page_replacement_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Apply one command to the shadow list and return the result it gives
  function automatic outcome_t lru_apply(lpr_pkg::cmd_t cmd, logic [PB-1:0] page);
    outcome_t      o;
    logic [PB-1:0] np [NF];
    int            i;
    int            n;
    bit            found;
    o.victim_valid = 1'b0;
    o.victim_page  = '0;
    o.status       = lpr_pkg::STAT_OK;
    case (cmd)
      lpr_pkg::CMD_INSERT: begin
        if (shadow_count >= NF) begin
          o.status = lpr_pkg::STAT_FULL;
        end else begin
          for (i = shadow_count; i > 0; i--) begin
            shadow_pages[i] = shadow_pages[i-1];
            shadow_marks[i] = shadow_marks[i-1];
          end
          shadow_pages[0] = page;
          shadow_marks[0] = 1'b1;
          shadow_count++;
        end
      end
      lpr_pkg::CMD_TOUCH: begin
        found = 1'b0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_pages[i] == page) begin
            shadow_marks[i] = 1'b1;
            found = 1'b1;
          end
        end
        if (!found) o.status = lpr_pkg::STAT_ABSENT;
      end
      lpr_pkg::CMD_EVICT: begin
        if (shadow_count == 0) begin
          o.status = lpr_pkg::STAT_EMPTY;
        end else begin
          shadow_count--;
          o.victim_valid = 1'b1;
          o.victim_page  = shadow_pages[shadow_count];
          shadow_marks[shadow_count] = 1'b0;
        end
      end
      default: begin
        // visited pages to the front in reverse walk order, the rest keep order
        n = 0;
        for (i = shadow_count; i > 0; i--) begin
          if (shadow_marks[i-1]) begin
            np[n] = shadow_pages[i-1];
            n++;
          end
        end
        for (i = 0; i < shadow_count; i++) begin
          if (!shadow_marks[i]) begin
            np[n] = shadow_pages[i];
            n++;
          end
        end
        for (i = 0; i < shadow_count; i++) begin
          shadow_pages[i] = np[i];
          shadow_marks[i] = 1'b0;
        end
      end
    endcase
    o.resident = shadow_count[CB-1:0];
    return o;
  endfunction

  function automatic void add_command(lpr_pkg::cmd_t cmd, logic [PB-1:0] page);
    command_item_t item;
    item.cmd   = cmd;
    item.page  = page;
    item.drain = 1'b0;
    command_queue.push_back(item);
  endfunction

  function automatic void add_drain();
    command_item_t item;
    item.cmd   = lpr_pkg::CMD_TICK;
    item.page  = '0;
    item.drain = 1'b1;
    command_queue.push_back(item);
  endfunction

  // Weighted command mix: fill, drain, balanced, uniform noise
  function automatic lpr_pkg::cmd_t pick_cmd(int mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      0:       return (r < 55) ? lpr_pkg::CMD_INSERT : (r < 75) ? lpr_pkg::CMD_TOUCH :
                      (r < 90) ? lpr_pkg::CMD_TICK : lpr_pkg::CMD_EVICT;
      1:       return (r < 55) ? lpr_pkg::CMD_EVICT : (r < 70) ? lpr_pkg::CMD_TOUCH :
                      (r < 85) ? lpr_pkg::CMD_TICK : lpr_pkg::CMD_INSERT;
      2:       return (r < 30) ? lpr_pkg::CMD_INSERT : (r < 60) ? lpr_pkg::CMD_TOUCH :
                      (r < 80) ? lpr_pkg::CMD_EVICT : lpr_pkg::CMD_TICK;
      default: return lpr_pkg::cmd_t'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [PB-1:0] pick_page(int mix);
    if (mix == 3 || $urandom_range(0, 9) == 0) return PB'($urandom);
    return page_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Predict on each accepted command word, check each accepted result word
  always @(posedge clk) begin : monitor
    outcome_t want;
    outcome_t got;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        awaited_outcomes.push_back(lru_apply(lpr_pkg::cmd_t'(in_tuser), in_tdata[PB-1:0]));
      end
      if (out_tvalid && out_tready) begin
        got.victim_valid = out_tuser[0];
        got.status       = lpr_pkg::status_t'(out_tuser[2:1]);
        got.victim_page  = out_tdata[PB-1:0];
        got.resident     = out_tdata[PB+CB-1:PB];
        if (awaited_outcomes.size() == 0) begin
          $error("result word with no command outstanding: tdata %h tuser %h",
                 out_tdata, out_tuser);
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.victim_valid !== want.victim_valid) begin
            $error("victim_valid: expected %0d, got %0d", want.victim_valid,
                   out_tuser[0]);
            errors++;
          end
          if (got.victim_page !== want.victim_page) begin
            $error("victim_page: expected %h, got %h", want.victim_page, got.victim_page);
            errors++;
          end
          if (out_tuser[2:1] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser[2:1]);
            errors++;
          end
          if (got.resident !== want.resident) begin
            $error("resident_count: expected %0d, got %0d", want.resident, got.resident);
            errors++;
          end
        end
      end
    end
  end

  // Sender: bursts of command words with random gaps, holding at drain markers
  always @(negedge clk) begin : driver
    command_item_t item;
    bit launch;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      launch = 1'b0;
      while (command_queue.size() > 0 && command_queue[0].drain &&
             awaited_outcomes.size() == 0)
        void'(command_queue.pop_front());
      if (gap_left > 0) begin
        gap_left--;
      end else if (command_queue.size() > 0 && !command_queue[0].drain) begin
        item = command_queue.pop_front();
        launch = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_tvalid <= launch;
      if (launch) begin
        in_tdata <= IN_W'(item.page);
        in_tuser <= item.cmd;
      end
    end
  end

  // Receiver: stall pattern changes among four random modes
  always @(negedge clk) begin
    stall_phase++;
    if (stall_phase % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 4) == 0);
      default: out_tready <= (stall_phase % 7) < 4;
    endcase
  end

  initial begin : stimulus
    int phase_len;
    int mix;
    int total;
    int j;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = lpr_pkg::CMD_INSERT;
    out_tready  = 1'b0;
    errors      = 0;
    cycles      = 0;
    in_taken    = 1'b0;
    burst_left  = 4;
    gap_left    = 0;
    stall_mode  = 0;
    stall_phase = 0;
    shadow_count = 0;
    for (j = 0; j < NF; j++) begin
      shadow_pages[j] = '0;
      shadow_marks[j] = 1'b0;
    end

    page_pool[0] = '0;
    page_pool[1] = '1;
    for (j = 2; j < POOL_SIZE; j++) page_pool[j] = PB'($urandom);

    // Directed: empty list cases, extreme ids, duplicates, tick ordering
    add_command(lpr_pkg::CMD_EVICT, '0);
    add_command(lpr_pkg::CMD_TICK, '0);
    add_command(lpr_pkg::CMD_TOUCH, '0);
    add_command(lpr_pkg::CMD_INSERT, '0);
    add_command(lpr_pkg::CMD_INSERT, '1);
    add_command(lpr_pkg::CMD_TOUCH, '1);
    add_command(lpr_pkg::CMD_TOUCH, PB'(5));
    add_command(lpr_pkg::CMD_TICK, '1);
    add_command(lpr_pkg::CMD_INSERT, '1);
    add_command(lpr_pkg::CMD_TICK, '0);
    add_command(lpr_pkg::CMD_TOUCH, '1);
    add_command(lpr_pkg::CMD_TOUCH, '0);
    add_command(lpr_pkg::CMD_TICK, '0);
    add_command(lpr_pkg::CMD_EVICT, '1);
    add_command(lpr_pkg::CMD_EVICT, '0);
    add_command(lpr_pkg::CMD_EVICT, '0);
    add_command(lpr_pkg::CMD_EVICT, '0);
    add_drain();

    // Random phases with different command mixes
    total = 0;
    while (total < 360) begin
      mix       = (total == 0) ? 0 : $urandom_range(0, 3);
      phase_len = $urandom_range(20, 50);
      for (j = 0; j < phase_len; j++) add_command(pick_cmd(mix), pick_page(mix));
      total += phase_len;
      if ($urandom_range(0, 2) == 0) add_drain();
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (command_queue.size() > 0 || in_tvalid || awaited_outcomes.size() > 0)
      @(negedge clk);
    repeat (40) @(negedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lpr_pkg.sv
src/lpr_ram.sv
src/lru_page_replacement_list.sv
src/lpr_checker.sv
bench/lru_page_replacement_list_tb.sv
